// ===== hdl/gtp_dd_pkg.sv =====
// Shared types, register codes and arithmetic helpers for the go-to-pose
// differential drive controller. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gtp_dd_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_DIST_TOL  = 3'd0;
    localparam logic [2:0] CFG_HEAD_TOL  = 3'd1;
    localparam logic [2:0] CFG_STEER_WIN = 3'd2;
    localparam logic [2:0] CFG_TURN_GAIN = 3'd3;
    localparam logic [2:0] CFG_DRIVE_SPD = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Q3.12 pi/2 and Q1.14 one
    localparam logic [12:0] HALF_PI_Q12 = 13'd6434;
    localparam int          DRIVE_ONE   = 16384;

    // CORDIC schedule: 17 micro-rotations, five per clock
    localparam int          CORDIC_STEPS    = 17;
    localparam int          STEPS_PER_CYCLE = 5;
    localparam logic [2:0]  CORDIC_LAST     = 3'd3;
    // divider: 24 quotient bits, four per clock
    localparam logic [2:0]  DIV_LAST        = 3'd5;

    // classified request passed from front to back
    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [14:0] now_heading;
        logic signed [15:0] head_err;
        logic               near;
        logic               arrived;
    } gtp_dd_item_t;

    // arctangent table, units of 2^-16 rad
    function automatic logic [15:0] atan_entry(input logic [4:0] i);
        logic [15:0] v;
        unique case (i)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // clamp to plus or minus one in Q1.14
    function automatic logic signed [15:0] sat_drive(input logic signed [25:0] v);
        logic signed [15:0] r;
        if (v > 26'sd16384) begin
            r = 16'sd16384;
        end else if (v < -26'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/gtp_dd_front.sv =====
// Front stage: takes a pose request, forms position and heading errors and
// classifies it (near target, arrived). Depends on gtp_dd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gtp_dd_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [15:0]        s_now_x,
    input  wire logic signed [15:0]        s_now_y,
    input  wire logic signed [14:0]        s_now_heading,
    input  wire logic signed [15:0]        s_goal_x,
    input  wire logic signed [15:0]        s_goal_y,
    input  wire logic signed [14:0]        s_goal_heading,
    input  wire logic [14:0]               dist_tol,
    input  wire logic [13:0]               head_tol,
    output logic                           item_valid,
    input  wire logic                      item_ready,
    output gtp_dd_pkg::gtp_dd_item_t       item
);
    import gtp_dd_pkg::*;

    logic         valid_reg;
    gtp_dd_item_t item_reg;
    gtp_dd_item_t item_next;

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [15:0] herr;
    logic [16:0]        adx;
    logic [16:0]        ady;
    logic [15:0]        aherr;

    // errors and classification
    always_comb begin
        dx    = {s_now_x[15], s_now_x} - {s_goal_x[15], s_goal_x};
        dy    = {s_now_y[15], s_now_y} - {s_goal_y[15], s_goal_y};
        herr  = {s_now_heading[14], s_now_heading} - {s_goal_heading[14], s_goal_heading};
        adx   = dx[16] ? 17'(-dx) : 17'(dx);
        ady   = dy[16] ? 17'(-dy) : 17'(dy);
        aherr = herr[15] ? 16'(-herr) : 16'(herr);
        item_next.dx          = dx;
        item_next.dy          = dy;
        item_next.now_heading = s_now_heading;
        item_next.head_err    = herr;
        item_next.near        = (adx <= {2'b00, dist_tol}) && (ady <= {2'b00, dist_tol});
        item_next.arrived     = item_next.near && (aherr <= {2'b00, head_tol});
    end

    assign s_ready    = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // output register toward the queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/gtp_dd_queue.sv =====
// Two-entry request queue between front and back stages.
// Depends on gtp_dd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gtp_dd_queue (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      wr_valid,
    output logic                           wr_ready,
    input  wire gtp_dd_pkg::gtp_dd_item_t  wr_item,
    output logic                           rd_valid,
    input  wire logic                      rd_ready,
    output gtp_dd_pkg::gtp_dd_item_t       rd_item
);
    import gtp_dd_pkg::*;

    gtp_dd_item_t mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         push;
    logic         pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/gtp_dd_back.sv =====
// Back stage: CORDIC bearing, proportional turn, mixing division and
// saturation, with the result register. Depends on gtp_dd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gtp_dd_back (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      item_valid,
    output logic                           item_ready,
    input  wire gtp_dd_pkg::gtp_dd_item_t  item,
    input  wire logic [13:0]               steer_win,
    input  wire logic [15:0]               turn_gain,
    input  wire logic [14:0]               drive_speed,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [15:0]             m_right_drive,
    output logic signed [15:0]             m_left_drive,
    output logic                           m_arrived
);
    import gtp_dd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CORD = 3'd1;
    localparam logic [2:0] ST_AIM  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_RND  = 3'd4;
    localparam logic [2:0] ST_SQ   = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [2:0]         cnt_reg;
    gtp_dd_item_t       item_reg;
    logic signed [35:0] x_reg;
    logic signed [35:0] y_reg;
    logic signed [19:0] z_reg;
    logic signed [15:0] err_reg;
    logic [14:0]        f_reg;
    logic signed [32:0] p_reg;
    logic [21:0]        at_reg;
    logic               tneg_reg;
    logic [22:0]        s_reg;
    logic               zero_reg;
    logic [23:0]        d_reg;
    logic [23:0]        nf_reg;
    logic [23:0]        nt_reg;
    logic [23:0]        remf_reg;
    logic [23:0]        remt_reg;
    logic [23:0]        qf_reg;
    logic [23:0]        qt_reg;
    logic               m_valid_reg;
    logic signed [15:0] right_reg;
    logic signed [15:0] left_reg;
    logic               arrived_reg;

    logic               out_free;
    logic [16:0]        adx;
    logic [16:0]        ady;

    assign out_free   = !m_valid_reg || m_ready;
    assign item_ready = (state_reg == ST_IDLE);
    assign adx        = item.dx[16] ? 17'(-item.dx) : 17'(item.dx);
    assign ady        = item.dy[16] ? 17'(-item.dy) : 17'(item.dy);

    // five CORDIC micro-rotations per clock
    logic signed [35:0] cx [STEPS_PER_CYCLE+1];
    logic signed [35:0] cy [STEPS_PER_CYCLE+1];
    logic signed [19:0] cz [STEPS_PER_CYCLE+1];
    always_comb begin
        logic [4:0] idx;
        cx[0] = x_reg;
        cy[0] = y_reg;
        cz[0] = z_reg;
        for (int k = 0; k < STEPS_PER_CYCLE; k++) begin
            idx = ({2'b00, cnt_reg} * 5'(STEPS_PER_CYCLE)) + 5'(k);
            if (idx < 5'(CORDIC_STEPS)) begin
                if (!cy[k][35]) begin
                    cx[k+1] = cx[k] + (cy[k] >>> idx);
                    cy[k+1] = cy[k] - (cx[k] >>> idx);
                    cz[k+1] = cz[k] + signed'({4'b0, atan_entry(idx)});
                end else begin
                    cx[k+1] = cx[k] - (cy[k] >>> idx);
                    cy[k+1] = cy[k] + (cx[k] >>> idx);
                    cz[k+1] = cz[k] - signed'({4'b0, atan_entry(idx)});
                end
            end else begin
                cx[k+1] = cx[k];
                cy[k+1] = cy[k];
                cz[k+1] = cz[k];
            end
        end
    end

    // bearing finish: round, clamp to 0..pi/2, set quadrant sign
    logic signed [19:0] zr;
    logic [12:0]        bmag;
    logic signed [13:0] bear;
    logic signed [15:0] aim_err;
    logic [15:0]        aim_abs;
    always_comb begin
        zr = (z_reg + 20'sd8) >>> 4;
        if (zr[19]) begin
            bmag = 13'd0;
        end else if (zr > signed'({7'b0, HALF_PI_Q12})) begin
            bmag = HALF_PI_Q12;
        end else begin
            bmag = zr[12:0];
        end
        if (item_reg.dx == 17'sd0) begin
            bear = 14'sd0;
        end else if (item_reg.dy == 17'sd0) begin
            bear = item_reg.dx[16] ? -signed'({1'b0, HALF_PI_Q12})
                                   : signed'({1'b0, HALF_PI_Q12});
        end else if (item_reg.dx[16] != item_reg.dy[16]) begin
            bear = -signed'({1'b0, bmag});
        end else begin
            bear = signed'({1'b0, bmag});
        end
        aim_err = {item_reg.now_heading[14], item_reg.now_heading} - 16'(bear);
        aim_abs = aim_err[15] ? 16'(-aim_err) : 16'(aim_err);
    end

    // turn value rounding
    logic [31:0] pmag;
    logic [31:0] psum;
    always_comb begin
        pmag = p_reg[32] ? 32'(-p_reg) : 32'(p_reg);
        psum = pmag + 32'd512;
    end

    // squares and dividends for the mixing division
    logic [45:0] nf_full;
    logic [45:0] nt_full;
    always_comb begin
        nf_full = {1'b0, 30'(f_reg) * 30'(f_reg), 1'b0} + 46'(s_reg);
        nt_full = {1'b0, 44'(at_reg) * 44'(at_reg), 1'b0} + 46'(s_reg);
    end

    // four restoring-division steps per clock, both quotients in parallel
    logic [24:0] rf;
    logic [24:0] rt;
    logic [23:0] remf_n;
    logic [23:0] remt_n;
    logic [23:0] nf_n;
    logic [23:0] nt_n;
    logic [23:0] qf_n;
    logic [23:0] qt_n;
    always_comb begin
        remf_n = remf_reg;
        remt_n = remt_reg;
        nf_n   = nf_reg;
        nt_n   = nt_reg;
        qf_n   = qf_reg;
        qt_n   = qt_reg;
        for (int k = 0; k < 4; k++) begin
            rf = {remf_n, nf_n[23]};
            rt = {remt_n, nt_n[23]};
            nf_n = {nf_n[22:0], 1'b0};
            nt_n = {nt_n[22:0], 1'b0};
            if (rf >= {1'b0, d_reg}) begin
                rf   = rf - {1'b0, d_reg};
                qf_n = {qf_n[22:0], 1'b1};
            end else begin
                qf_n = {qf_n[22:0], 1'b0};
            end
            if (rt >= {1'b0, d_reg}) begin
                rt   = rt - {1'b0, d_reg};
                qt_n = {qt_n[22:0], 1'b1};
            end else begin
                qt_n = {qt_n[22:0], 1'b0};
            end
            remf_n = rf[23:0];
            remt_n = rt[23:0];
        end
    end

    // mix and saturate
    logic signed [25:0] fm;
    logic signed [25:0] tm;
    always_comb begin
        if (zero_reg) begin
            fm = 26'sd0;
            tm = 26'sd0;
        end else begin
            fm = signed'({2'b0, qf_reg});
            tm = tneg_reg ? -signed'({2'b0, qt_reg}) : signed'({2'b0, qt_reg});
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    if (item.near || item.dx == 17'sd0 || item.dy == 17'sd0) begin
                        state_next = ST_AIM;
                    end else begin
                        state_next = ST_CORD;
                    end
                end
            end
            ST_CORD: begin
                if (cnt_reg == CORDIC_LAST) begin
                    state_next = ST_AIM;
                end
            end
            ST_AIM:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_RND;
            ST_RND:  state_next = ST_SQ;
            ST_SQ:   state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                item_reg <= item;
                x_reg    <= signed'(36'({ady, 14'b0}));
                y_reg    <= signed'(36'({adx, 14'b0}));
                z_reg    <= 20'sd0;
                cnt_reg  <= 3'd0;
            end
            ST_CORD: begin
                x_reg   <= cx[STEPS_PER_CYCLE];
                y_reg   <= cy[STEPS_PER_CYCLE];
                z_reg   <= cz[STEPS_PER_CYCLE];
                cnt_reg <= cnt_reg + 3'd1;
            end
            ST_AIM: begin
                if (item_reg.near) begin
                    err_reg <= item_reg.arrived ? 16'sd0 : item_reg.head_err;
                    f_reg   <= 15'd0;
                end else begin
                    err_reg <= aim_err;
                    f_reg   <= (aim_abs <= {2'b00, steer_win}) ? drive_speed : 15'd0;
                end
            end
            ST_MUL: begin
                p_reg <= 33'(err_reg) * 33'(signed'({1'b0, turn_gain}));
            end
            ST_RND: begin
                at_reg   <= psum[31:10];
                tneg_reg <= p_reg[32];
                s_reg    <= 23'(f_reg) + 23'(psum[31:10]);
            end
            ST_SQ: begin
                zero_reg <= item_reg.arrived || (s_reg == 23'd0);
                d_reg    <= {s_reg, 1'b0};
                remf_reg <= {2'b00, nf_full[45:24]};
                remt_reg <= {2'b00, nt_full[45:24]};
                nf_reg   <= nf_full[23:0];
                nt_reg   <= nt_full[23:0];
                qf_reg   <= 24'd0;
                qt_reg   <= 24'd0;
                cnt_reg  <= 3'd0;
            end
            ST_DIV: begin
                remf_reg <= remf_n;
                remt_reg <= remt_n;
                nf_reg   <= nf_n;
                nt_reg   <= nt_n;
                qf_reg   <= qf_n;
                qt_reg   <= qt_n;
                cnt_reg  <= cnt_reg + 3'd1;
            end
            ST_OUT: begin
                if (out_free) begin
                    right_reg   <= sat_drive(fm - tm);
                    left_reg    <= sat_drive(fm + tm);
                    arrived_reg <= item_reg.arrived;
                end
            end
            default: begin
                cnt_reg <= 3'd0;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_right_drive = right_reg;
    assign m_left_drive  = left_reg;
    assign m_arrived     = arrived_reg;

endmodule
`default_nettype wire

// ===== hdl/go_to_pose_differential_drive_unit.sv =====
// Go-to-pose controller for a differential drive base: top level with the
// configuration registers. Depends on gtp_dd_pkg, gtp_dd_front, gtp_dd_queue, gtp_dd_back.
//
// Usage:
//   s_* carries one pose request (current and target pose) per valid/ready
//   handshake; m_* returns one result per request: right and left wheel
//   commands (Q1.14, saturated to +/-1.0) and the arrival flag, in order.
//   cfg_wr_en/cfg_index/cfg_wdata write the five tuning registers; write them
//   only while no request is in flight. Unknown indexes are ignored.
// Flow:
//   The front registers a classified request and hands it to a two-entry
//   queue. The back works on one request at a time: CORDIC (five rotations
//   per clock, skipped near the target or on an axis), then aim, multiply,
//   round and square, a 4-bit-per-clock divider and an output state. The
//   back stage sequencer takes no new request until the last result has
//   left its output state.
// Reset: aresetn (synchronous, active low) empties the queue and the result
//   register and restores the register defaults. A stalled m_ready holds the
//   result; the front and queue keep accepting until three requests wait.
`timescale 1ns / 1ps
`default_nettype none
module go_to_pose_differential_drive_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [15:0]                    s_now_x,
    input  wire logic signed [15:0]                    s_now_y,
    input  wire logic signed [14:0]                    s_now_heading,
    input  wire logic signed [15:0]                    s_goal_x,
    input  wire logic signed [15:0]                    s_goal_y,
    input  wire logic signed [14:0]                    s_goal_heading,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [15:0]                         m_right_drive,
    output logic signed [15:0]                         m_left_drive,
    output logic                                       m_arrived,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [gtp_dd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [gtp_dd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import gtp_dd_pkg::*;

    logic [14:0] dist_tol_reg;
    logic [13:0] head_tol_reg;
    logic [13:0] steer_win_reg;
    logic [15:0] turn_gain_reg;
    logic [14:0] drive_speed_reg;

    // tuning registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_tol_reg    <= 15'd10;
            head_tol_reg    <= 14'd164;
            steer_win_reg   <= 14'd2048;
            turn_gain_reg   <= 16'd3686;
            drive_speed_reg <= 15'd8192;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DIST_TOL:  dist_tol_reg    <= cfg_wdata[14:0];
                CFG_HEAD_TOL:  head_tol_reg    <= cfg_wdata[13:0];
                CFG_STEER_WIN: steer_win_reg   <= cfg_wdata[13:0];
                CFG_TURN_GAIN: turn_gain_reg   <= cfg_wdata[15:0];
                CFG_DRIVE_SPD: drive_speed_reg <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    logic         front_valid;
    logic         front_ready;
    gtp_dd_item_t front_item;
    logic         queue_valid;
    logic         queue_ready;
    gtp_dd_item_t queue_item;

    gtp_dd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_now_x        (s_now_x),
        .s_now_y        (s_now_y),
        .s_now_heading  (s_now_heading),
        .s_goal_x       (s_goal_x),
        .s_goal_y       (s_goal_y),
        .s_goal_heading (s_goal_heading),
        .dist_tol       (dist_tol_reg),
        .head_tol       (head_tol_reg),
        .item_valid     (front_valid),
        .item_ready     (front_ready),
        .item           (front_item)
    );

    gtp_dd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_item  (front_item),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_item  (queue_item)
    );

    gtp_dd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (queue_valid),
        .item_ready    (queue_ready),
        .item          (queue_item),
        .steer_win     (steer_win_reg),
        .turn_gain     (turn_gain_reg),
        .drive_speed   (drive_speed_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_right_drive (m_right_drive),
        .m_left_drive  (m_left_drive),
        .m_arrived     (m_arrived)
    );

endmodule
`default_nettype wire

// ===== sim/gtp_dd_checker.sv =====
// Checker for the go-to-pose differential drive unit: watches the request,
// result and register ports, predicts each result and compares. Uses gtp_dd_pkg.
`timescale 1ns / 1ps
module gtp_dd_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [15:0]                  s_now_x,
    input  logic signed [15:0]                  s_now_y,
    input  logic signed [14:0]                  s_now_heading,
    input  logic signed [15:0]                  s_goal_x,
    input  logic signed [15:0]                  s_goal_y,
    input  logic signed [14:0]                  s_goal_heading,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [15:0]                  m_right_drive,
    input  logic signed [15:0]                  m_left_drive,
    input  logic                                m_arrived,
    input  logic                                cfg_wr_en,
    input  logic [gtp_dd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gtp_dd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  result_count,
    output int                                  arrived_count
);
    import gtp_dd_pkg::*;

    typedef struct packed {
        logic signed [15:0] right;
        logic signed [15:0] left;
        logic               arrived;
    } wheel_cmd_t;

    // tuning registers as seen by the block
    logic [14:0] dist_tol;
    logic [13:0] head_tol;
    logic [13:0] steer_win;
    logic [15:0] turn_gain;
    logic [14:0] drive_spd;

    wheel_cmd_t expected_cmd_q[$];

    function automatic longint abs_l(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // CORDIC vectoring bearing, Q3.12
    function automatic longint aim_bearing(input longint dx, input longint dy);
        longint x, y, z, r, xs, ys;
        longint angle_step[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                   256, 128, 64, 32, 16, 8, 4, 2, 1};
        if (dx == 0) return 0;
        if (dy == 0) return (dx > 0) ? 6434 : -6434;
        x = abs_l(dy) * 16384;
        y = abs_l(dx) * 16384;
        z = 0;
        for (int i = 0; i < 17; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += angle_step[i];
            end else begin
                x -= ys; y += xs; z -= angle_step[i];
            end
        end
        r = (z + 8) >>> 4;
        if (r < 0) r = 0;
        if (r > 6434) r = 6434;
        return ((dx < 0) != (dy < 0)) ? -r : r;
    endfunction

    function automatic longint turn_cmd(input longint err);
        longint p, q;
        p = err * longint'(turn_gain);
        q = (abs_l(p) + 512) / 1024;
        return (p < 0) ? -q : q;
    endfunction

    function automatic longint mix_share(input longint v, input longint s);
        longint a, q;
        a = abs_l(v);
        q = (2 * a * a + s) / (2 * s);
        return (v < 0) ? -q : q;
    endfunction

    function automatic longint clamp_one(input longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic wheel_cmd_t predict_wheels(
        input logic signed [15:0] nx, input logic signed [15:0] ny,
        input logic signed [14:0] nh, input logic signed [15:0] gx,
        input logic signed [15:0] gy, input logic signed [14:0] gh);
        longint dx, dy, b, f, t, s, fm, tm;
        wheel_cmd_t c;
        dx = longint'(nx) - longint'(gx);
        dy = longint'(ny) - longint'(gy);
        f = 0; t = 0; fm = 0; tm = 0;
        c.arrived = 1'b0;
        if (abs_l(dx) <= dist_tol && abs_l(dy) <= dist_tol) begin
            if (abs_l(longint'(nh) - gh) <= head_tol) c.arrived = 1'b1;
            else t = turn_cmd(longint'(nh) - gh);
        end else begin
            b = aim_bearing(dx, dy);
            if (abs_l(longint'(nh) - b) <= steer_win) f = drive_spd;
            t = turn_cmd(longint'(nh) - b);
        end
        s = abs_l(f) + abs_l(t);
        if (!c.arrived && s != 0) begin
            fm = mix_share(f, s);
            tm = mix_share(t, s);
        end
        c.right = 16'(clamp_one(fm - tm));
        c.left  = 16'(clamp_one(fm + tm));
        return c;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    assign pending = expected_cmd_q.size();

    initial begin
        fail_count = 0;
        result_count = 0;
        arrived_count = 0;
    end

    always @(posedge aclk) begin
        wheel_cmd_t want;
        if (!aresetn) begin
            dist_tol  <= 15'd10;
            head_tol  <= 14'd164;
            steer_win <= 14'd2048;
            turn_gain <= 16'd3686;
            drive_spd <= 15'd8192;
            expected_cmd_q.delete();
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DIST_TOL:  dist_tol  <= cfg_wdata[14:0];
                    CFG_HEAD_TOL:  head_tol  <= cfg_wdata[13:0];
                    CFG_STEER_WIN: steer_win <= cfg_wdata[13:0];
                    CFG_TURN_GAIN: turn_gain <= cfg_wdata;
                    CFG_DRIVE_SPD: drive_spd <= cfg_wdata[14:0];
                    default: ;
                endcase
            end
            // accepted request
            if (s_valid && s_ready)
                expected_cmd_q.push_back(predict_wheels(s_now_x, s_now_y, s_now_heading,
                                                        s_goal_x, s_goal_y, s_goal_heading));
            // accepted result
            if (m_valid && m_ready) begin
                result_count++;
                if (m_arrived) arrived_count++;
                if (expected_cmd_q.size() == 0) begin
                    $display("[%0t] unexpected result with no request waiting", $time);
                    fail_count++;
                end else begin
                    want = expected_cmd_q.pop_front();
                    if (m_right_drive !== want.right)
                        report_mismatch("right_drive", m_right_drive, want.right);
                    if (m_left_drive !== want.left)
                        report_mismatch("left_drive", m_left_drive, want.left);
                    if (m_arrived !== want.arrived)
                        report_mismatch("arrived", m_arrived, want.arrived);
                end
            end
        end
    end
endmodule

// ===== sim/tb_go_to_pose_differential_drive_unit.sv =====
// Testbench top for go_to_pose_differential_drive_unit: drives pose requests,
// register settings and result back-pressure. Uses gtp_dd_pkg and gtp_dd_checker.
`timescale 1ns / 1ps
module tb_go_to_pose_differential_drive_unit;
    import gtp_dd_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SEG_ITEMS   = 190;
    localparam logic [2:0]  CFG_SPARE   = 3'd7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_now_x = '0, s_now_y = '0, s_goal_x = '0, s_goal_y = '0;
    logic signed [14:0] s_now_heading = '0, s_goal_heading = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_right_drive, m_left_drive;
    logic m_arrived;
    logic cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int fail_count, pending, result_count, arrived_count;
    int tx_idle = 13, rx_idle = 82;
    int cycles = 0;

    always #4 aclk = ~aclk;

    go_to_pose_differential_drive_unit i_dut (.*);

    gtp_dd_checker i_checker (.*);

    // result back-pressure
    always @(posedge aclk) m_ready <= aresetn && ($urandom_range(0, 99) >= rx_idle);

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_pose(input logic [15:0] nx, input logic [15:0] ny,
                             input logic [14:0] nh, input logic [15:0] gx,
                             input logic [15:0] gy, input logic [14:0] gh);
        while ($urandom_range(0, 99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_now_x <= nx; s_now_y <= ny; s_now_heading <= nh;
        s_goal_x <= gx; s_goal_y <= gy; s_goal_heading <= gh;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // all five registers plus one unused index, one write per cycle
    task automatic write_tuning(input logic [15:0] dt, input logic [15:0] ht,
                                input logic [15:0] sw, input logic [15:0] tg,
                                input logic [15:0] ds);
        logic [15:0] vals[6];
        logic [2:0]  idx[6];
        vals = '{dt, ht, sw, tg, ds, 16'($urandom)};
        idx  = '{CFG_DIST_TOL, CFG_HEAD_TOL, CFG_STEER_WIN, CFG_TURN_GAIN,
                 CFG_DRIVE_SPD, CFG_SPARE};
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    function automatic logic [14:0] pick_heading();
        if ($urandom_range(0, 9) == 0) return 15'($urandom);
        return 15'($urandom_range(0, 25736) - 12868);
    endfunction

    // random request: near target, on an axis, within +/-2000, or anywhere
    task automatic random_pose(input int near_span);
        logic [15:0] nx, ny, gx, gy;
        logic [14:0] nh, gh;
        int kind;
        kind = $urandom_range(0, 9);
        nx = 16'($urandom); ny = 16'($urandom);
        nh = pick_heading();
        gh = pick_heading();
        if (kind < 4) begin
            gx = nx + 16'($urandom_range(0, 2 * near_span) - near_span);
            gy = ny + 16'($urandom_range(0, 2 * near_span) - near_span);
            if (kind == 0) gh = nh + 15'($urandom_range(0, 400) - 200);
        end else if (kind == 4) begin
            gx = nx; gy = 16'($urandom);
        end else if (kind == 5) begin
            gx = 16'($urandom); gy = ny;
        end else if (kind == 6) begin
            gx = nx + 16'($urandom_range(0, 4000) - 2000);
            gy = ny + 16'($urandom_range(0, 4000) - 2000);
        end else begin
            gx = 16'($urandom); gy = 16'($urandom);
        end
        send_pose(nx, ny, nh, gx, gy, gh);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed requests under reset tuning
        send_pose(0, 0, 0, 0, 0, 0);                          // arrived
        send_pose(5, -10, 100, 0, 0, -60);                    // arrived at edges
        send_pose(0, 0, 15'sd12868, 0, 0, -15'sd12868);       // turn in place, positive
        send_pose(3, 3, -15'sd12868, 0, 0, 15'sd12868);       // turn in place, negative
        send_pose(0, 1000, 0, 0, 0, 0);                       // on the y axis
        send_pose(1000, 0, 6434, 0, 0, 0);                    // dy zero, positive
        send_pose(-1000, 0, -6434, 0, 0, 0);                  // dy zero, negative
        send_pose(500, 500, 3217, 0, 0, 0);
        send_pose(-500, 500, -3217, 0, 0, 0);
        send_pose(500, -500, -3217, 0, 0, 0);
        send_pose(-500, -500, 3217, 0, 0, 0);
        send_pose(16'h7FFF, 16'h7FFF, 0, 16'h8000, 16'h8000, 0);
        send_pose(16'h8000, 16'h8000, 0, 16'h7FFF, 16'h7FFF, 0);
        send_pose(16'h7FFF, 16'h8000, 15'h3FFF, 16'h8000, 16'h7FFF, 15'h4000);
        send_pose(11, 0, 0, 0, 0, 0);                         // just outside tolerance
        send_pose(0, 0, 15'h4000, 0, 0, 15'h3FFF);            // heading bit extremes
        send_pose(20, 9000, 2040, 0, 0, 0);                   // steer window edge
        send_pose(12, 5, 15'h3FFF, 0, 0, 15'h4000);
        wait_drained();

        // phases of tuning and idling
        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin tx_idle = 13; rx_idle = 82; end
                1: begin tx_idle = 82; rx_idle = 13; end
                default: begin tx_idle = 0; rx_idle = 0; end
            endcase
            case (seg)
                1: write_tuning(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: write_tuning(0, 0, 0, 0, 0);
                3: write_tuning(16'($urandom_range(0, 300)), 16'($urandom_range(0, 12868)),
                                16'($urandom_range(0, 12868)), 16'($urandom),
                                16'($urandom_range(0, 16384)));
                4: write_tuning(32767, 12868, 12868, 65535, 16384);
                5: write_tuning(10, 164, 2048, 3686, 8192);
                default: ;
            endcase
            for (int n = 0; n < SEG_ITEMS; n++)
                random_pose((seg == 2) ? 1 : 40);
            wait_drained();
        end

        $display("%0d results checked, %0d with arrival, over six tuning and idling phases",
                 result_count, arrived_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
